// ===== design/assert_macros.svh =====
// Assertion helpers for the design.
// Each macro is compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/combrank_pkg.sv =====
package combrank_pkg;

   // Request type codes.
   localparam logic [1:0] REQ_GENERATE = 2'd0;
   localparam logic [1:0] REQ_QUERY    = 2'd1;
   localparam logic [1:0] REQ_CLEAR    = 2'd2;

   // Result status codes.
   localparam logic [2:0] ST_GENERATED = 3'd0;
   localparam logic [2:0] ST_FOUND     = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_EXHAUSTED = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_CLEARED   = 3'd5;

   // Configuration register indexes and widths.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_SITES     = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_ELECTRONS = 1'b1;
   localparam logic [CSR_DATA_W-1:0]  NUM_SITES_RESET     = 5'd9;
   localparam logic [CSR_DATA_W-1:0]  NUM_ELECTRONS_RESET = 5'd1;

   // A generate run is cut after this many results.
   localparam int MAX_RESULTS = 16;
   localparam int RUN_W       = $clog2(MAX_RESULTS);

   // Request word.
   typedef struct packed {
      logic [1:0] req_type;
      logic [4:0] site;
      logic       last_site;
   } req_word_type;

   // Result word.
   typedef struct packed {
      logic [2:0]  status;
      logic [13:0] index;
      logic [15:0] mask;
      logic [4:0]  site_res;
      logic        last;
   } rsp_word_type;

endpackage

// ===== design/combination_table_rank_lookup.sv =====
// Channel    Ports                           Handshake
// request    start, busy, req_data           taken when start is high and busy is low
// result     rsp_valid, rsp_data             one word per strobe cycle, never held off
// settings   csr_we, csr_index, csr_wdata    written at every edge with csr_we high
//
// Generate: GEN_A and GEN_B form the next mask or report exhausted or full; EMIT then walks
// the new mask site by site up to the highest occupied one (at most n). The last query site
// starts a binary search that alternates SRCH_ADR and SRCH_CMP, through the single read port.
// The table memory needs no clearing pass after reset; the entry count bounds every read.
// Results appear in the cycle after they are formed.
`include "assert_macros.svh"

module combination_table_rank_lookup #(
   parameter int MAX_SITES   = 16,
   parameter int TABLE_DEPTH = 16384
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  combrank_pkg::req_word_type               req_data,
   output logic                                     rsp_valid,
   output combrank_pkg::rsp_word_type               rsp_data,
   input  logic                                     csr_we,
   input  logic [combrank_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [combrank_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CNT_W = $clog2(MAX_SITES + 1);
   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CW    = $clog2(TABLE_DEPTH + 1);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_GEN_A    = 3'd1;
   localparam logic [2:0] S_GEN_B    = 3'd2;
   localparam logic [2:0] S_EMIT     = 3'd3;
   localparam logic [2:0] S_SRCH_ADR = 3'd4;
   localparam logic [2:0] S_SRCH_CMP = 3'd5;

   typedef logic [MAX_SITES-1:0] site_mask_type;
   typedef logic [MAX_SITES:0]   ext_mask_type;

   // Registers and their next values.
   logic [2:0]                                  state_ff, state_in;
   logic [CW-1:0]                               count_ff, count_in;
   site_mask_type                               current_ff, current_in;
   site_mask_type                               query_ff, query_in;
   site_mask_type                               want_ff, want_in;
   site_mask_type                               work_ff, work_in;
   ext_mask_type                                sum_ff, sum_in;
   logic [CNT_W-1:0]                            tz_ff, tz_in;
   logic [CNT_W-1:0]                            site_cnt_ff, site_cnt_in;
   logic [combrank_pkg::RUN_W-1:0]              run_cnt_ff, run_cnt_in;
   logic [AW-1:0]                               pos_ff, pos_in;
   logic [CW-1:0]                               lo_ff, lo_in;
   logic [CW-1:0]                               hi_ff, hi_in;
   logic [combrank_pkg::CSR_DATA_W-1:0]         num_sites_ff, num_sites_in;
   logic [combrank_pkg::CSR_DATA_W-1:0]         num_electrons_ff, num_electrons_in;
   logic                                        rsp_valid_ff, rsp_valid_in;
   combrank_pkg::rsp_word_type                  rsp_data_ff, rsp_data_in;
   site_mask_type                               rd_data_ff;

   // Table memory and its ports.
   site_mask_type                               table_mem [TABLE_DEPTH];
   logic                                        mem_we;
   logic [AW-1:0]                               mem_waddr;
   site_mask_type                               mem_wdata;
   logic [AW-1:0]                               mem_raddr;

   // Combinational helpers.
   logic                                        accept;
   logic [CNT_W-1:0]                            n_eff;
   logic [CNT_W-1:0]                            k_eff;
   site_mask_type                               site_bit;
   logic [CNT_W-1:0]                            tz_c;
   logic [CNT_W:0]                              shamt;
   ext_mask_type                                x_ext;
   ext_mask_type                                nx_ext;
   logic                                        exhausted;
   site_mask_type                               new_mask;
   logic [CW:0]                                 mid_sum;
   logic                                        run_last;
   logic                                        query_last_taken;
   logic                                        clear_taken;
   logic                                        clear_reply;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Effective site and electron counts, clamped to their legal ranges.
   always_comb begin
      if (num_sites_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (32'(num_sites_ff) > MAX_SITES) begin
         n_eff = CNT_W'(MAX_SITES);
      end else begin
         n_eff = CNT_W'(num_sites_ff);
      end
      if (num_electrons_ff == '0) begin
         k_eff = CNT_W'(1);
      end else if (32'(num_electrons_ff) > 32'(n_eff)) begin
         k_eff = n_eff;
      end else begin
         k_eff = CNT_W'(num_electrons_ff);
      end
   end

   // Query site decoded into a one-hot mask bit; sites outside 1..n set nothing.
   always_comb begin
      site_bit = '0;
      if (req_data.site != 5'd0 && 32'(req_data.site) <= 32'(n_eff)) begin
         site_bit = site_mask_type'(1) << (req_data.site - 5'd1);
      end
   end

   // Trailing zero count of the current mask.
   always_comb begin
      tz_c = CNT_W'(MAX_SITES);
      for (int i = MAX_SITES - 1; i >= 0; i--) begin
         if (current_ff[i]) begin
            tz_c = CNT_W'(i);
         end
      end
   end

   // Second half of the next-combination step: the low bit moved up, the rest refilled.
   always_comb begin
      x_ext  = {1'b0, current_ff};
      shamt  = (CNT_W+1)'(tz_ff) + (CNT_W+1)'(2);
      nx_ext = sum_ff | ((sum_ff ^ x_ext) >> shamt);
      if (count_ff == '0) begin
         new_mask  = ~(site_mask_type'('1) << k_eff);
         exhausted = 1'b0;
      end else begin
         new_mask  = site_mask_type'(nx_ext);
         exhausted = (current_ff == '0) || ((nx_ext >> n_eff) != '0);
      end
   end

   // Binary search midpoint, rounded down.
   assign mid_sum   = (CW+1)'(lo_ff) + (CW+1)'(hi_ff) - (CW+1)'(1);
   assign mem_raddr = AW'(mid_sum >> 1);

   assign run_last = ((work_ff >> 1) == '0) ||
                     (run_cnt_ff == combrank_pkg::RUN_W'(combrank_pkg::MAX_RESULTS - 1));

   // Sequencer: next state and next values of all registers.
   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      current_in       = current_ff;
      query_in         = query_ff;
      want_in          = want_ff;
      work_in          = work_ff;
      sum_in           = sum_ff;
      tz_in            = tz_ff;
      site_cnt_in      = site_cnt_ff;
      run_cnt_in       = run_cnt_ff;
      pos_in           = pos_ff;
      lo_in            = lo_ff;
      hi_in            = hi_ff;
      num_sites_in     = num_sites_ff;
      num_electrons_in = num_electrons_ff;
      rsp_valid_in     = 1'b0;
      rsp_data_in      = rsp_data_ff;
      mem_we           = 1'b0;
      mem_waddr        = AW'(count_ff);
      mem_wdata        = new_mask;

      // Settings writes.
      if (csr_we) begin
         if (csr_index == combrank_pkg::CSR_NUM_SITES) begin
            num_sites_in = csr_wdata;
         end else begin
            num_electrons_in = csr_wdata;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.req_type)
                  combrank_pkg::REQ_GENERATE: begin
                     state_in = S_GEN_A;
                  end
                  combrank_pkg::REQ_QUERY: begin
                     if (req_data.last_site) begin
                        want_in  = query_ff | site_bit;
                        query_in = '0;
                        lo_in    = '0;
                        hi_in    = count_ff;
                        state_in = S_SRCH_ADR;
                     end else begin
                        query_in = query_ff | site_bit;
                     end
                  end
                  combrank_pkg::REQ_CLEAR: begin
                     count_in             = '0;
                     current_in           = '0;
                     query_in             = '0;
                     rsp_valid_in         = 1'b1;
                     rsp_data_in.status   = combrank_pkg::ST_CLEARED;
                     rsp_data_in.index    = '0;
                     rsp_data_in.mask     = '0;
                     rsp_data_in.site_res = '0;
                     rsp_data_in.last     = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // First half of the step: add the lowest set bit, note its position.
         S_GEN_A: begin
            sum_in   = x_ext + (x_ext & (-x_ext));
            tz_in    = tz_c;
            state_in = S_GEN_B;
         end

         // Decide exhausted, full or store the new entry.
         S_GEN_B: begin
            if (exhausted || 32'(count_ff) >= TABLE_DEPTH) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.status   = exhausted ? combrank_pkg::ST_EXHAUSTED
                                                : combrank_pkg::ST_FULL;
               rsp_data_in.index    = 14'(count_ff);
               rsp_data_in.mask     = 16'(current_ff);
               rsp_data_in.site_res = '0;
               rsp_data_in.last     = 1'b1;
               state_in             = S_IDLE;
            end else begin
               mem_we      = 1'b1;
               current_in  = new_mask;
               work_in     = new_mask;
               pos_in      = AW'(count_ff);
               count_in    = count_ff + CW'(1);
               site_cnt_in = CNT_W'(1);
               run_cnt_in  = '0;
               state_in    = S_EMIT;
            end
         end

         // Walk the new mask one site per cycle, one word per occupied site.
         S_EMIT: begin
            work_in     = work_ff >> 1;
            site_cnt_in = site_cnt_ff + CNT_W'(1);
            if (work_ff[0]) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.status   = combrank_pkg::ST_GENERATED;
               rsp_data_in.index    = 14'(pos_ff);
               rsp_data_in.mask     = 16'(current_ff);
               rsp_data_in.site_res = 5'(site_cnt_ff);
               rsp_data_in.last     = run_last;
               run_cnt_in           = run_cnt_ff + combrank_pkg::RUN_W'(1);
               if (run_last) begin
                  state_in = S_IDLE;
               end
            end
         end

         // Issue the table read at the midpoint, or report a miss.
         S_SRCH_ADR: begin
            if (lo_ff < hi_ff) begin
               pos_in   = mem_raddr;
               state_in = S_SRCH_CMP;
            end else begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.status   = combrank_pkg::ST_NOT_FOUND;
               rsp_data_in.index    = '0;
               rsp_data_in.mask     = 16'(want_ff);
               rsp_data_in.site_res = '0;
               rsp_data_in.last     = 1'b1;
               state_in             = S_IDLE;
            end
         end

         // Compare against the entry read and narrow the range.
         S_SRCH_CMP: begin
            if (want_ff > rd_data_ff) begin
               lo_in    = CW'(pos_ff) + CW'(1);
               state_in = S_SRCH_ADR;
            end else if (want_ff < rd_data_ff) begin
               hi_in    = CW'(pos_ff);
               state_in = S_SRCH_ADR;
            end else begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.status   = combrank_pkg::ST_FOUND;
               rsp_data_in.index    = 14'(pos_ff);
               rsp_data_in.mask     = 16'(want_ff);
               rsp_data_in.site_res = '0;
               rsp_data_in.last     = 1'b1;
               state_in             = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         count_ff         <= '0;
         current_ff       <= '0;
         query_ff         <= '0;
         num_sites_ff     <= combrank_pkg::NUM_SITES_RESET;
         num_electrons_ff <= combrank_pkg::NUM_ELECTRONS_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         count_ff         <= count_in;
         current_ff       <= current_in;
         query_ff         <= query_in;
         num_sites_ff     <= num_sites_in;
         num_electrons_ff <= num_electrons_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      want_ff     <= want_in;
      work_ff     <= work_in;
      sum_ff      <= sum_in;
      tz_ff       <= tz_in;
      site_cnt_ff <= site_cnt_in;
      run_cnt_ff  <= run_cnt_in;
      pos_ff      <= pos_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= table_mem[mem_raddr];
   end

   // Handshake events watched by the checks.
   assign query_last_taken = accept && (req_data.req_type == combrank_pkg::REQ_QUERY) &&
                             req_data.last_site;
   assign clear_taken      = accept && (req_data.req_type == combrank_pkg::REQ_CLEAR);
   assign clear_reply      = rsp_valid_ff && (rsp_data_ff.status == combrank_pkg::ST_CLEARED);

   // Checks.
   `ASSERT_ALWAYS(a_count_bound, clock, reset, 32'(count_ff) <= TABLE_DEPTH)
   `ASSERT_IMPLIES(a_run_continues, clock, reset, rsp_valid_ff && !rsp_data_ff.last, busy)
   `ASSERT_NEXT(a_query_mask_drop, clock, reset, query_last_taken, query_ff == '0)
   `ASSERT_NEXT(a_clear_reply, clock, reset, clear_taken, clear_reply)

endmodule

// ===== bench/combination_table_rank_lookup_tb.sv =====
`timescale 1ns / 100ps

module combination_table_rank_lookup_tb;

   // The request type that the block ignores.
   localparam logic [1:0] REQ_UNUSED  = 2'd3;
   localparam int         TABLE_SLOTS = 16384;
   localparam int         SITE_LIMIT  = 16;
   localparam int         RANDOM_WORDS = 450;

   logic                                 clock;
   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   combrank_pkg::req_word_type           req_data;
   logic                                 rsp_valid;
   combrank_pkg::rsp_word_type           rsp_data;
   logic                                 csr_we;
   logic [combrank_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [combrank_pkg::CSR_DATA_W-1:0]  csr_wdata;

   // Shadow of the block: stored table, generator state and settings.
   logic [15:0] mdl_masks [0:TABLE_SLOTS-1];
   int          mdl_count;
   logic [15:0] mdl_current;
   logic [15:0] mdl_query;
   logic [4:0]  mdl_sites;
   logic [4:0]  mdl_electrons;

   combrank_pkg::rsp_word_type outstanding_rsp[$];
   int           errors;
   int           words_sent;
   int           words_checked;
   int           status_seen [0:7];
   bit           no_gaps;

   combination_table_rank_lookup i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #2_000_000;
      $display("combination_table_rank_lookup verification failed");
      $finish;
   end

   function automatic void push_result(logic [2:0] status, int unsigned index,
                                       logic [15:0] mask, int unsigned site_res,
                                       logic last);
      outstanding_rsp.push_back(combrank_pkg::rsp_word_type'{status: status,
                                                             index: 14'(index),
                                                             mask: mask,
                                                             site_res: 5'(site_res),
                                                             last: last});
   endfunction

   // Work out the result words that one accepted request word causes.
   function automatic void rank_table_step(combrank_pkg::req_word_type w);
      int unsigned     n;
      int unsigned     k;
      longint unsigned x;
      longint unsigned t;
      longint unsigned y;
      longint unsigned q;
      longint unsigned nm;
      bit              fits;
      int              lo;
      int              hi;
      int              mid;
      int              runs;
      logic [15:0]     want;

      // Out-of-range settings are clamped.
      n = (mdl_sites < 1) ? 1 : (mdl_sites > SITE_LIMIT) ? SITE_LIMIT : mdl_sites;
      k = (mdl_electrons < 1) ? 1 : (mdl_electrons > n) ? n : mdl_electrons;

      case (w.req_type)
         combrank_pkg::REQ_GENERATE: begin
            fits = 1'b1;
            nm = 0;
            if (mdl_count == 0) begin
               nm = (64'd1 << k) - 1;
            end else begin
               // Next combination with the same number of set bits.
               x = mdl_current;
               if (x == 0) begin
                  fits = 1'b0;
               end else begin
                  t  = x | (x - 1);
                  y  = t + 1;
                  q  = (y & (~y + 1)) / (x & (~x + 1));
                  nm = y | ((q >> 1) - 1);
                  fits = (nm >> n) == 0;
               end
            end
            if (!fits) begin
               push_result(combrank_pkg::ST_EXHAUSTED, mdl_count, mdl_current, 0, 1'b1);
            end else if (mdl_count >= TABLE_SLOTS) begin
               push_result(combrank_pkg::ST_FULL, mdl_count, mdl_current, 0, 1'b1);
            end else begin
               mdl_masks[mdl_count] = nm[15:0];
               mdl_current = nm[15:0];
               runs = 0;
               for (int b = 0; b < n && runs < combrank_pkg::MAX_RESULTS; b++) begin
                  if (nm[b]) begin
                     push_result(combrank_pkg::ST_GENERATED, mdl_count, nm[15:0], b + 1,
                                 1'b0);
                     runs++;
                  end
               end
               if (runs > 0) outstanding_rsp[outstanding_rsp.size() - 1].last = 1'b1;
               mdl_count++;
            end
         end
         combrank_pkg::REQ_QUERY: begin
            if (w.site >= 1 && w.site <= n) mdl_query[w.site - 1] = 1'b1;
            if (w.last_site) begin
               want = mdl_query;
               mdl_query = '0;
               lo = 0;
               hi = mdl_count - 1;
               while (lo <= hi) begin
                  mid = (lo + hi) / 2;
                  if (want > mdl_masks[mid]) begin
                     lo = mid + 1;
                  end else if (want < mdl_masks[mid]) begin
                     hi = mid - 1;
                  end else begin
                     break;
                  end
               end
               if (lo <= hi) begin
                  push_result(combrank_pkg::ST_FOUND, mid, want, 0, 1'b1);
               end else begin
                  push_result(combrank_pkg::ST_NOT_FOUND, 0, want, 0, 1'b1);
               end
            end
         end
         combrank_pkg::REQ_CLEAR: begin
            mdl_count = 0;
            mdl_current = '0;
            mdl_query = '0;
            push_result(combrank_pkg::ST_CLEARED, 0, '0, 0, 1'b1);
         end
         default: begin
         end
      endcase
   endfunction

   task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
         errors++;
      end
   endtask

   // Every result word is compared with the oldest expected one.
   always @(posedge clock) begin
      combrank_pkg::rsp_word_type exp_word;
      if (!reset && rsp_valid) begin
         if (outstanding_rsp.size() == 0) begin
            $error("result word with none expected: status %0d index %0d mask %h",
                   rsp_data.status, rsp_data.index, rsp_data.mask);
            errors++;
         end else begin
            exp_word = outstanding_rsp.pop_front();
            check_field("status", exp_word.status, rsp_data.status);
            check_field("index", exp_word.index, rsp_data.index);
            check_field("mask", exp_word.mask, rsp_data.mask);
            check_field("site_res", exp_word.site_res, rsp_data.site_res);
            check_field("last", exp_word.last, rsp_data.last);
            status_seen[exp_word.status]++;
            words_checked++;
         end
      end
   end

   // Send one request word, after a random gap unless gaps are off.
   task automatic send_req(logic [1:0] kind, logic [4:0] site, logic last_flag);
      int gap;
      int pick;
      gap = 0;
      @(negedge clock);
      if (!no_gaps) begin
         pick = $urandom_range(0, 99);
         if (pick >= 90) begin
            gap = $urandom_range(8, 40);
         end else if (pick >= 55) begin
            gap = $urandom_range(1, 3);
         end
      end
      if (gap != 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data = combrank_pkg::req_word_type'{req_type: kind, site: site,
                                              last_site: last_flag};
      start = 1'b1;
      do @(posedge clock); while (busy);
      rank_table_step(req_data);
      if (kind != REQ_UNUSED) words_sent++;
   endtask

   // Drop start and wait until the block has delivered everything and gone quiet.
   task automatic wait_idle();
      @(negedge clock);
      start = 1'b0;
      while (outstanding_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_csr(logic [combrank_pkg::CSR_INDEX_W-1:0] idx,
                            logic [combrank_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == combrank_pkg::CSR_NUM_SITES) begin
         mdl_sites = value;
      end else begin
         mdl_electrons = value;
      end
   endtask

   // Ask for one stored entry, its sites in random order, sometimes with noise.
   task automatic query_stored();
      logic [4:0]  sites[$];
      logic [15:0] mask;
      logic [4:0]  tmp;
      int          j;
      int          style;
      mask = mdl_masks[$urandom_range(0, mdl_count - 1)];
      for (int b = 0; b < 16; b++) begin
         if (mask[b]) sites.push_back(5'(b + 1));
      end
      for (int i = sites.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = sites[i];
         sites[i] = sites[j];
         sites[j] = tmp;
      end
      style = $urandom_range(0, 9);
      // A repeated site or one that sets no bit, sent ahead of the rest.
      if (style == 0) sites.push_front(sites[$urandom_range(0, sites.size() - 1)]);
      if (style == 1) sites.push_front(5'($urandom_range(17, 31)));
      // One site missing, so the lookup usually misses.
      if (style == 2 && sites.size() > 1) void'(sites.pop_back());
      // Every site ahead of the final word, which carries site 0.
      if (style == 3) sites.push_back(5'd0);
      for (int i = 0; i < sites.size(); i++) begin
         send_req(combrank_pkg::REQ_QUERY, sites[i], i == sites.size() - 1);
      end
   endtask

   task automatic query_random();
      int count;
      count = $urandom_range(1, 6);
      for (int i = 0; i < count; i++) begin
         send_req(combrank_pkg::REQ_QUERY, 5'($urandom_range(0, 31)), i == count - 1);
      end
   endtask

   // Reset settings: single-site masks at nine sites.
   task automatic test_reset_settings();
      send_req(combrank_pkg::REQ_GENERATE, 5'd0, 1'b0);
      send_req(combrank_pkg::REQ_GENERATE, 5'd0, 1'b0);
      send_req(combrank_pkg::REQ_QUERY, 5'd2, 1'b1);
      // Site above n sets no bit.
      send_req(combrank_pkg::REQ_QUERY, 5'd12, 1'b1);
      send_req(REQ_UNUSED, 5'd31, 1'b1);
      send_req(combrank_pkg::REQ_CLEAR, 5'd0, 1'b0);
      wait_idle();
   endtask

   // Zero settings clamp to one site and one electron.
   task automatic test_clamped_minimum();
      write_csr(combrank_pkg::CSR_NUM_SITES, 5'd0);
      write_csr(combrank_pkg::CSR_NUM_ELECTRONS, 5'd0);
      send_req(combrank_pkg::REQ_GENERATE, 5'd0, 1'b0);
      send_req(combrank_pkg::REQ_GENERATE, 5'd0, 1'b0);
      send_req(combrank_pkg::REQ_QUERY, 5'd1, 1'b0);
      send_req(combrank_pkg::REQ_QUERY, 5'd1, 1'b1);
      send_req(combrank_pkg::REQ_CLEAR, 5'd0, 1'b0);
      wait_idle();
   endtask

   // Largest settings clamp to sixteen sites; the run is cut at sixteen words.
   task automatic test_full_width_run();
      write_csr(combrank_pkg::CSR_NUM_SITES, 5'd31);
      write_csr(combrank_pkg::CSR_NUM_ELECTRONS, 5'd31);
      send_req(combrank_pkg::REQ_GENERATE, 5'd0, 1'b0);
      send_req(combrank_pkg::REQ_GENERATE, 5'd0, 1'b0);
      send_req(combrank_pkg::REQ_QUERY, 5'd0, 1'b0);
      send_req(combrank_pkg::REQ_QUERY, 5'd16, 1'b1);
      wait_idle();
   endtask

   // Narrowing n mid-table keeps the table and stops generation early.
   task automatic test_midtable_change();
      send_req(combrank_pkg::REQ_CLEAR, 5'd0, 1'b0);
      wait_idle();
      write_csr(combrank_pkg::CSR_NUM_SITES, 5'd4);
      write_csr(combrank_pkg::CSR_NUM_ELECTRONS, 5'd2);
      send_req(combrank_pkg::REQ_GENERATE, 5'd0, 1'b0);
      send_req(combrank_pkg::REQ_GENERATE, 5'd0, 1'b0);
      wait_idle();
      write_csr(combrank_pkg::CSR_NUM_SITES, 5'd3);
      send_req(combrank_pkg::REQ_GENERATE, 5'd0, 1'b0);
      send_req(combrank_pkg::REQ_GENERATE, 5'd0, 1'b0);
      wait_idle();
   endtask

   // Phases of random settings; mostly table builds and lookups of stored entries.
   task automatic test_random_traffic();
      int pick;
      int sent_at_start;
      sent_at_start = words_sent;
      while (words_sent - sent_at_start < RANDOM_WORDS) begin
         wait_idle();
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            write_csr(combrank_pkg::CSR_NUM_SITES, 5'($urandom_range(0, 31)));
         end else if (pick < 30) begin
            write_csr(combrank_pkg::CSR_NUM_SITES, 5'd16);
         end else begin
            write_csr(combrank_pkg::CSR_NUM_SITES, 5'($urandom_range(1, 8)));
         end
         if ($urandom_range(0, 4) == 0) begin
            write_csr(combrank_pkg::CSR_NUM_ELECTRONS, 5'($urandom_range(0, 31)));
         end else begin
            write_csr(combrank_pkg::CSR_NUM_ELECTRONS, 5'($urandom_range(1, 5)));
         end
         no_gaps = ($urandom_range(0, 3) == 0);
         // Most phases start from an empty table; the rest keep building.
         if ($urandom_range(0, 3) != 0) begin
            send_req(combrank_pkg::REQ_CLEAR, 5'($urandom_range(0, 31)), 1'b0);
         end
         repeat ($urandom_range(10, 40)) begin
            // Stop as soon as the planned number of words has gone out.
            if (words_sent - sent_at_start >= RANDOM_WORDS) break;
            pick = $urandom_range(0, 99);
            if (pick < 40 || (pick < 75 && mdl_count == 0)) begin
               send_req(combrank_pkg::REQ_GENERATE, 5'($urandom_range(0, 31)),
                        1'($urandom_range(0, 1)));
            end else if (pick < 75) begin
               query_stored();
            end else if (pick < 85) begin
               query_random();
            end else if (pick < 95) begin
               send_req(REQ_UNUSED, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
            end else begin
               send_req(combrank_pkg::REQ_CLEAR, 5'($urandom_range(0, 31)),
                        1'($urandom_range(0, 1)));
            end
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      errors = 0;
      words_sent = 0;
      words_checked = 0;
      no_gaps = 1'b0;
      foreach (status_seen[i]) status_seen[i] = 0;
      mdl_count = 0;
      mdl_current = '0;
      mdl_query = '0;
      mdl_sites = combrank_pkg::NUM_SITES_RESET;
      mdl_electrons = combrank_pkg::NUM_ELECTRONS_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_settings();
      test_clamped_minimum();
      test_full_width_run();
      test_midtable_change();
      test_random_traffic();

      wait_idle();
      repeat (40) @(posedge clock);
      $display("Sent %0d request words; checked %0d result words.",
               words_sent, words_checked);
      $display("Site words %0d, found %0d, not found %0d, exhausted %0d, cleared %0d.",
               status_seen[combrank_pkg::ST_GENERATED], status_seen[combrank_pkg::ST_FOUND],
               status_seen[combrank_pkg::ST_NOT_FOUND],
               status_seen[combrank_pkg::ST_EXHAUSTED],
               status_seen[combrank_pkg::ST_CLEARED]);
      if (errors == 0 && outstanding_rsp.size() == 0) begin
         $display("combination_table_rank_lookup verification clean");
      end else begin
         $display("combination_table_rank_lookup verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/combrank_pkg.sv
design/combination_table_rank_lookup.sv
bench/combination_table_rank_lookup_tb.sv
